// ===== rtl/quicksort_lomuto_defines.svh =====
// Assertion macros for the checker file of the sorting block.
`ifndef QUICKSORT_LOMUTO_DEFINES_SVH
`define QUICKSORT_LOMUTO_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QSL_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define QSL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/qsl_pkg.sv =====
// Shared types and constants of the quicksort block.
package qsl_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int VALUE_W       = 32;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_START,
        ST_POP,
        ST_RANGE,
        ST_CHECK,
        ST_PIVOT,
        ST_READ_J,
        ST_TEST_J,
        ST_SWAP_J,
        ST_SWAP_ST,
        ST_FIN_HI,
        ST_FIN_ST,
        ST_PUSH_L,
        ST_PUSH_R,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_HOLD
    } qsl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // store the accepted request, or flag overflow
        logic start;       // push the whole list if it holds two or more, reset output index
        logic pop_rd;      // pop a range, read its stack entry
        logic range_ld;    // capture lo/hi from the stack read data
        logic piv_rd;      // read buf[hi]
        logic piv_ld;      // capture pivot, store = j = lo
        logic j_rd;        // read buf[j]
        logic j_ld;        // capture buf[j]
        logic skip;        // j++
        logic bump;        // store++, j++ without moving data
        logic st_rd;       // read buf[store]
        logic st_wr_j;     // buf[j] = read data
        logic wr_st_tmp;   // buf[store] = captured buf[j], store++, j++
        logic fs_wr_hi;    // buf[hi] = read data
        logic fs_wr_st;    // buf[store] = pivot
        logic push_left;   // push [lo, q-1] when it holds two or more
        logic push_right;  // push [q+1, hi] when it holds two or more
        logic out_rd;      // read buf[k]
        logic out_ld;      // load the output register
        logic out_next;    // k++
        logic clear;       // end of run: empty buffer, stack, overflow flag
    } qsl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic depth_zero;
        logic range_empty;
        logic j_at_hi;
        logic vj_le;
        logic store_eq_j;
        logic count_zero;
        logic out_last;
    } qsl_status_t;

endpackage

// ===== rtl/qsl_ram.sv =====
// Generic RAM: one write port, one read port with registered read data.
module qsl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/qsl_datapath.sv =====
// Datapath of the sorter: item buffer, range stack, partition registers, output register.
module qsl_datapath #(
    parameter int MAX_ITEMS = qsl_pkg::MAX_ITEMS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  qsl_pkg::qsl_cmd_t                  cmd,
    input  logic signed [qsl_pkg::VALUE_W-1:0] s_value,
    output qsl_pkg::qsl_status_t               status,
    output logic signed [qsl_pkg::VALUE_W-1:0] m_sorted_value,
    output logic                               m_last_out,
    output logic                               m_overflowed
);
    import qsl_pkg::*;

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = IDX_W + 1;
    localparam int SE_W  = 2 * IDX_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);

    logic [CNT_W-1:0]   count_reg;
    logic               overflow_reg;
    logic [CNT_W-1:0]   depth_reg;
    logic [IDX_W-1:0]   lo_reg;
    logic [IDX_W-1:0]   hi_reg;
    logic [IDX_W-1:0]   store_reg;
    logic [IDX_W-1:0]   j_reg;
    logic [IDX_W-1:0]   k_reg;
    logic [VALUE_W-1:0] pivot_reg;
    logic [VALUE_W-1:0] vj_reg;
    logic [VALUE_W-1:0] m_sorted_value_reg;
    logic               m_last_out_reg;
    logic               m_overflowed_reg;

    logic               buf_we;
    logic [IDX_W-1:0]   buf_waddr;
    logic [VALUE_W-1:0] buf_wdata;
    logic               buf_re;
    logic [IDX_W-1:0]   buf_raddr;
    logic [VALUE_W-1:0] buf_rdata;

    logic               stk_we;
    logic [IDX_W-1:0]   stk_waddr;
    logic [SE_W-1:0]    stk_wdata;
    logic [IDX_W-1:0]   stk_raddr;
    logic [SE_W-1:0]    stk_rdata;

    logic [CNT_W-1:0]   depth_dec;
    logic [CNT_W-1:0]   count_dec;
    logic [IDX_W:0]     lo_x;
    logic [IDX_W:0]     hi_x;
    logic [IDX_W:0]     store_x;
    logic               room;
    logic               store_ok;
    logic               start_en;
    logic               push_l_en;
    logic               push_r_en;

    assign depth_dec = depth_reg - 1'b1;
    assign count_dec = count_reg - 1'b1;
    assign lo_x      = {1'b0, lo_reg};
    assign hi_x      = {1'b0, hi_reg};
    assign store_x   = {1'b0, store_reg};
    assign room      = depth_reg < MAX_CNT;
    assign store_ok  = count_reg < MAX_CNT;
    assign start_en  = cmd.start && (count_reg >= CNT_W'(2));
    // Push only subranges of two or more elements.
    assign push_l_en = cmd.push_left && (store_x > lo_x + 1'b1) && room;
    assign push_r_en = cmd.push_right && (store_x + 1'b1 < hi_x) && room;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            depth_reg    <= '0;
        end else if (cmd.clear) begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            depth_reg    <= '0;
        end else begin
            if (cmd.load) begin
                if (store_ok) begin
                    count_reg <= count_reg + 1'b1;
                end else begin
                    overflow_reg <= 1'b1;
                end
            end
            if (cmd.start) begin
                depth_reg <= start_en ? CNT_W'(1) : '0;
            end else if (cmd.pop_rd) begin
                depth_reg <= depth_dec;
            end else if (push_l_en || push_r_en) begin
                depth_reg <= depth_reg + 1'b1;
            end
        end
    end

    // Partition and output registers
    always_ff @(posedge aclk) begin
        if (cmd.range_ld) begin
            lo_reg <= stk_rdata[SE_W-1:IDX_W];
            hi_reg <= stk_rdata[IDX_W-1:0];
        end
        if (cmd.piv_ld) begin
            pivot_reg <= buf_rdata;
            store_reg <= lo_reg;
            j_reg     <= lo_reg;
        end
        if (cmd.j_ld) begin
            vj_reg <= buf_rdata;
        end
        if (cmd.skip) begin
            j_reg <= j_reg + 1'b1;
        end
        if (cmd.bump || cmd.wr_st_tmp) begin
            store_reg <= store_reg + 1'b1;
            j_reg     <= j_reg + 1'b1;
        end
        if (cmd.start) begin
            k_reg <= '0;
        end else if (cmd.out_next) begin
            k_reg <= k_reg + 1'b1;
        end
        if (cmd.out_ld) begin
            m_sorted_value_reg <= buf_rdata;
            m_last_out_reg     <= status.out_last;
            m_overflowed_reg   <= overflow_reg;
        end
    end

    // Buffer port muxes
    always_comb begin
        buf_we    = 1'b0;
        buf_waddr = '0;
        buf_wdata = '0;
        if (cmd.load && store_ok) begin
            buf_we    = 1'b1;
            buf_waddr = count_reg[IDX_W-1:0];
            buf_wdata = s_value;
        end else if (cmd.st_wr_j) begin
            buf_we    = 1'b1;
            buf_waddr = j_reg;
            buf_wdata = buf_rdata;
        end else if (cmd.wr_st_tmp) begin
            buf_we    = 1'b1;
            buf_waddr = store_reg;
            buf_wdata = vj_reg;
        end else if (cmd.fs_wr_hi) begin
            buf_we    = 1'b1;
            buf_waddr = hi_reg;
            buf_wdata = buf_rdata;
        end else if (cmd.fs_wr_st) begin
            buf_we    = 1'b1;
            buf_waddr = store_reg;
            buf_wdata = pivot_reg;
        end
    end

    always_comb begin
        buf_re    = cmd.piv_rd || cmd.j_rd || cmd.st_rd || cmd.out_rd;
        buf_raddr = k_reg;
        if (cmd.piv_rd) begin
            buf_raddr = hi_reg;
        end else if (cmd.j_rd) begin
            buf_raddr = j_reg;
        end else if (cmd.st_rd) begin
            buf_raddr = store_reg;
        end
    end

    // Stack port muxes
    always_comb begin
        stk_we    = start_en || push_l_en || push_r_en;
        stk_waddr = depth_reg[IDX_W-1:0];
        stk_wdata = {store_reg + 1'b1, hi_reg};
        if (cmd.start) begin
            stk_waddr = '0;
            stk_wdata = {{IDX_W{1'b0}}, count_dec[IDX_W-1:0]};
        end else if (cmd.push_left) begin
            stk_wdata = {lo_reg, store_reg - 1'b1};
        end
    end

    assign stk_raddr = depth_dec[IDX_W-1:0];

    qsl_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_ITEMS)
    ) u_item_ram (
        .aclk  (aclk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (buf_wdata),
        .re    (buf_re),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    qsl_ram #(
        .WIDTH (SE_W),
        .DEPTH (MAX_ITEMS)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (cmd.pop_rd),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign status.depth_zero  = depth_reg == '0;
    assign status.range_empty = lo_reg >= hi_reg;
    assign status.j_at_hi     = j_reg == hi_reg;
    assign status.vj_le       = $signed(buf_rdata) <= $signed(pivot_reg);
    assign status.store_eq_j  = store_reg == j_reg;
    assign status.count_zero  = count_reg == '0;
    assign status.out_last    = ({1'b0, k_reg} + 1'b1) == count_reg;

    assign m_sorted_value = m_sorted_value_reg;
    assign m_last_out     = m_last_out_reg;
    assign m_overflowed   = m_overflowed_reg;
endmodule

// ===== rtl/qsl_ctrl.sv =====
// Controller of the sorter: sequences loading, partitioning and read-out.
module qsl_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_last,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  qsl_pkg::qsl_status_t status,
    output qsl_pkg::qsl_cmd_t    cmd
);
    import qsl_pkg::*;

    qsl_state_t state_reg;
    qsl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (s_last) begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START: begin
                cmd.start  = 1'b1;
                state_next = ST_POP;
            end
            ST_POP: begin
                if (status.depth_zero) begin
                    state_next = ST_OUT_RD;
                end else begin
                    cmd.pop_rd = 1'b1;
                    state_next = ST_RANGE;
                end
            end
            ST_RANGE: begin
                cmd.range_ld = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_CHECK: begin
                if (status.range_empty) begin
                    state_next = ST_POP;
                end else begin
                    cmd.piv_rd = 1'b1;
                    state_next = ST_PIVOT;
                end
            end
            ST_PIVOT: begin
                cmd.piv_ld = 1'b1;
                state_next = ST_READ_J;
            end
            ST_READ_J: begin
                // At the pivot: fetch buf[store] for the closing swap.
                if (status.j_at_hi) begin
                    cmd.st_rd  = 1'b1;
                    state_next = ST_FIN_HI;
                end else begin
                    cmd.j_rd   = 1'b1;
                    state_next = ST_TEST_J;
                end
            end
            ST_TEST_J: begin
                if (!status.vj_le) begin
                    cmd.skip   = 1'b1;
                    state_next = ST_READ_J;
                end else if (status.store_eq_j) begin
                    cmd.bump   = 1'b1;
                    state_next = ST_READ_J;
                end else begin
                    cmd.j_ld   = 1'b1;
                    cmd.st_rd  = 1'b1;
                    state_next = ST_SWAP_J;
                end
            end
            ST_SWAP_J: begin
                cmd.st_wr_j = 1'b1;
                state_next  = ST_SWAP_ST;
            end
            ST_SWAP_ST: begin
                cmd.wr_st_tmp = 1'b1;
                state_next    = ST_READ_J;
            end
            ST_FIN_HI: begin
                cmd.fs_wr_hi = 1'b1;
                state_next   = ST_FIN_ST;
            end
            ST_FIN_ST: begin
                cmd.fs_wr_st = 1'b1;
                state_next   = ST_PUSH_L;
            end
            ST_PUSH_L: begin
                cmd.push_left = 1'b1;
                state_next    = ST_PUSH_R;
            end
            ST_PUSH_R: begin
                cmd.push_right = 1'b1;
                state_next     = ST_POP;
            end
            ST_OUT_RD: begin
                if (status.count_zero) begin
                    cmd.clear  = 1'b1;
                    state_next = ST_LOAD;
                end else begin
                    cmd.out_rd = 1'b1;
                    state_next = ST_OUT_LD;
                end
            end
            ST_OUT_LD: begin
                cmd.out_ld = 1'b1;
                state_next = ST_OUT_HOLD;
            end
            ST_OUT_HOLD: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (status.out_last) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_LOAD;
                    end else begin
                        cmd.out_next = 1'b1;
                        state_next   = ST_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end
endmodule

// ===== rtl/quicksort_lomuto.sv =====
// Top level of the quicksort sorter: controller and datapath.
//
// Requests carry one signed 32-bit value each and are stored at one per cycle;
// up to MAX_ITEMS are kept and any beyond that are dropped and flagged on every
// result of the run. A request with s_last set (stored or dropped) starts an
// in-place quicksort with Lomuto partitioning over a range stack held in a
// second RAM; s_ready stays low from then until the last sorted value has been
// taken. All buffer traffic goes through one single-port-per-direction RAM with
// registered read, so each scanned element is first read and then tested, and a
// swap adds one write to buf[j] and one to buf[store]. Each result is read from
// the buffer, loaded into the output register and held until m_ready takes it.
// No clearing pass is needed after reset.
module quicksort_lomuto #(
    parameter int MAX_ITEMS = qsl_pkg::MAX_ITEMS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [qsl_pkg::VALUE_W-1:0] s_value,
    input  logic                               s_last,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [qsl_pkg::VALUE_W-1:0] m_sorted_value,
    output logic                               m_last_out,
    output logic                               m_overflowed
);
    import qsl_pkg::*;

    qsl_cmd_t    cmd;
    qsl_status_t status;

    qsl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_last),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    qsl_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .s_value        (s_value),
        .status         (status),
        .m_sorted_value (m_sorted_value),
        .m_last_out     (m_last_out),
        .m_overflowed   (m_overflowed)
    );
endmodule

// ===== rtl/qsl_checker.sv =====
// Port-level checks of the sorter, bound to the top level.
`include "quicksort_lomuto_defines.svh"

module qsl_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [qsl_pkg::VALUE_W-1:0] m_sorted_value,
    input logic                               m_last_out,
    input logic                               m_overflowed
);
    // Hold a stalled result.
    `QSL_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
                     m_valid && $stable(m_sorted_value) && $stable(m_last_out)
                     && $stable(m_overflowed))

    // Loading and read-out never overlap.
    `QSL_ASSERT_NOW(a_no_overlap, aclk, aresetn, 1'b1, !(s_ready && m_valid))

    // Drop valid after the final result of a run.
    `QSL_ASSERT_NEXT(a_end_of_run, aclk, aresetn, m_valid && m_ready && m_last_out, !m_valid)

    // Keep the input closed while a run still has results to deliver.
    `QSL_ASSERT_NEXT(a_run_busy, aclk, aresetn, m_valid && m_ready && !m_last_out, !s_ready)
endmodule

bind quicksort_lomuto qsl_checker u_qsl_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_sorted_value (m_sorted_value),
    .m_last_out     (m_last_out),
    .m_overflowed   (m_overflowed)
);

// ===== verif/tb_top.sv =====
// Testbench for the quicksort sorter: random list stimulus, sort predictor, result checks.
`timescale 1ns / 100ps

module tb_top;
    import qsl_pkg::*;

    localparam int CAPACITY = MAX_ITEMS_DEF;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        bit                        last;
        bit                        ovf;
    } sorted_item_t;

    typedef enum int {FILL_RANDOM, FILL_NARROW, FILL_RISING, FILL_FALLING} fill_mode_t;

    // Collects each list, sorts it on the last request and checks the read-out.
    class sort_scoreboard;
        logic signed [VALUE_W-1:0] held[$];
        bit                        dropped;
        sorted_item_t              sorted_q[$];
        int                        errors;
        int                        checked;
        int                        lists;
        int                        ovf_lists;

        function void note_request(logic signed [VALUE_W-1:0] v, bit l);
            logic signed [VALUE_W-1:0] key;
            sorted_item_t              it;
            int                        i;
            int                        j;
            if (held.size() < CAPACITY)
                held.push_back(v);
            else
                dropped = 1'b1;
            if (!l)
                return;
            for (i = 1; i < held.size(); i++) begin
                key = held[i];
                j = i - 1;
                while (j >= 0 && held[j] > key) begin
                    held[j+1] = held[j];
                    j--;
                end
                held[j+1] = key;
            end
            for (i = 0; i < held.size(); i++) begin
                it.value = held[i];
                it.last  = (i == held.size() - 1);
                it.ovf   = dropped;
                sorted_q.push_back(it);
            end
            lists++;
            if (dropped)
                ovf_lists++;
            held.delete();
            dropped = 1'b0;
        endfunction

        function void check_result(logic signed [VALUE_W-1:0] v, bit l, bit o);
            sorted_item_t want;
            if (sorted_q.size() == 0) begin
                $error("unexpected result: sorted_value %0d last_out %0b overflowed %0b",
                       v, l, o);
                errors++;
                return;
            end
            want = sorted_q.pop_front();
            checked++;
            if (v !== want.value) begin
                $error("sorted_value: expected %0d, got %0d", want.value, v);
                errors++;
            end
            if (l !== want.last) begin
                $error("last_out: expected %0b, got %0b", want.last, l);
                errors++;
            end
            if (o !== want.ovf) begin
                $error("overflowed: expected %0b, got %0b", want.ovf, o);
                errors++;
            end
        endfunction

        function int pending();
            return sorted_q.size();
        endfunction
    endclass

    logic                      aclk;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [VALUE_W-1:0] s_value = '0;
    logic                      s_last  = 1'b0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [VALUE_W-1:0] m_sorted_value;
    logic                      m_last_out;
    logic                      m_overflowed;

    sort_scoreboard            sb = new();
    logic signed [VALUE_W-1:0] list_vals[$];
    int                        requests_sent;
    int                        burst_left;
    int                        rx_cycle;
    int                        rx_hold;

    quicksort_lomuto #(
        .MAX_ITEMS (CAPACITY)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sorted_value (m_sorted_value),
        .m_last_out     (m_last_out),
        .m_overflowed   (m_overflowed)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Receiver: check on handshake, then pick the next ready from the current stall mode.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_sorted_value, m_last_out, m_overflowed);
        rx_cycle++;
        case ((rx_cycle / 300) % 4)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 1) == 1);
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: begin
                if (rx_hold > 0) begin
                    rx_hold--;
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        rx_hold = $urandom_range(5, 20);
                end
            end
        endcase
    end

    task automatic send_item(input logic signed [VALUE_W-1:0] v, input bit l);
        s_valid <= 1'b1;
        s_value <= v;
        s_last  <= l;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_request(v, l);
        requests_sent++;
        // End the burst: drop valid for a random gap.
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(0, 12);
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_list();
        int i;
        for (i = 0; i < list_vals.size(); i++)
            send_item(list_vals[i], i == list_vals.size() - 1);
    endtask

    task automatic build_list(input int len, input fill_mode_t mode);
        logic signed [VALUE_W-1:0] v;
        int                        i;
        list_vals.delete();
        v = $urandom;
        for (i = 0; i < len; i++) begin
            case (mode)
                FILL_NARROW:  v = $signed($urandom_range(0, 8)) - 4;
                FILL_RISING:  v = (i == 0) ? $signed($urandom_range(0, 1000)) - 500
                                           : v + $urandom_range(0, 3);
                FILL_FALLING: v = (i == 0) ? $signed($urandom_range(0, 1000)) - 500
                                           : v - $urandom_range(0, 3);
                default:      v = $urandom;
            endcase
            if ($urandom_range(0, 15) == 0)
                v = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
            list_vals.push_back(v);
        end
    endtask

    initial begin
        int         list_no;
        int         len;
        int         pick;
        int         waited;
        fill_mode_t mode;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        burst_left = $urandom_range(0, 12);

        list_vals = '{VAL_MAX};
        send_list();
        list_vals = '{VAL_MIN, VAL_MAX, 0, -1, 1, VAL_MIN};
        send_list();
        list_vals = '{7, 7, 7};
        send_list();
        list_vals = '{-3, -2, -1, 0, 1};
        send_list();
        list_vals = '{9, 4, 2, -8};
        send_list();
        list_vals = '{2, 1};
        send_list();

        // Start with one list past capacity and one exactly full, then mostly short ones.
        list_no = 0;
        while (requests_sent < 310) begin
            pick = $urandom_range(0, 99);
            if (list_no == 0)
                len = CAPACITY + 2;
            else if (list_no == 1)
                len = CAPACITY;
            else if (pick < 70)
                len = $urandom_range(1, 10);
            else if (pick < 92)
                len = $urandom_range(11, 40);
            else if (pick < 97)
                len = CAPACITY;
            else
                len = $urandom_range(CAPACITY + 1, CAPACITY + 6);
            mode = fill_mode_t'($urandom_range(0, 3));
            build_list(len, mode);
            send_list();
            list_no++;
        end
        s_valid <= 1'b0;

        waited = 0;
        while (sb.pending() != 0 && waited < 200_000) begin
            @(posedge aclk);
            waited++;
        end
        if (sb.pending() != 0) begin
            $error("%0d sorted values never arrived", sb.pending());
            sb.errors++;
        end
        repeat (50) @(posedge aclk);

        $display("Sent %0d requests in %0d lists (%0d past capacity); checked %0d sorted values.",
                 requests_sent, sb.lists, sb.ovf_lists, sb.checked);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
